>>> hw/rtl/assert_macros.svh
// assertion macros shared by the queue, back end and top-level rtl files of the hash core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define SBH_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sbh assertion failed");

// condition must never be seen outside reset
`define SBH_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("sbh forbidden condition seen");

`else

`define SBH_ASSERT(lbl, clk, rstn, prop)
`define SBH_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> hw/rtl/sbh_pkg.sv
// shared types, constants and mixing functions of the string bucket hash core
package sbh_pkg;

  localparam int HashW        = 32;
  localparam int CharW        = 8;
  localparam int CountW       = 16;
  localparam int IndexW       = 16;
  localparam int IndexBitsDef = 16;
  localparam int QueueDepth   = 2;

  localparam int MixShl   = 10;
  localparam int MixShr   = 6;
  localparam int FinShl1  = 3;
  localparam int FinShr   = 11;
  localparam int FinShl2  = 15;

  localparam logic [CountW-1:0] BucketCountRst = CountW'(16);

  // register index of the configuration port
  localparam logic RegBucketCount = 1'b0;

  // one key hash handed from the front to the queue
  typedef struct packed {
    logic             push;
    logic [HashW-1:0] hash;
  } q_wr_t;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic             empty;
    logic [HashW-1:0] hash;
  } q_rd_t;

  function automatic logic [HashW-1:0] mix_char(input logic [HashW-1:0] h,
                                                input logic [CharW-1:0] c);
    logic [HashW-1:0] t;
    t = h + {{(HashW-CharW){c[CharW-1]}}, c};
    t = t + (t << MixShl);
    t = t ^ (t >> MixShr);
    return t;
  endfunction

  function automatic logic [HashW-1:0] finish_mix(input logic [HashW-1:0] h);
    logic [HashW-1:0] t;
    t = h + (h << FinShl1);
    t = t ^ (t >> FinShr);
    t = t + (t << FinShl2);
    return t;
  endfunction

endpackage

>>> hw/rtl/sbh_front.sv
// front end: takes key characters and keeps the running hash of the key
module sbh_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic [sbh_pkg::CharW-1:0] key_char_i,
  input  logic            has_char_i,
  input  logic            last_i,
  output sbh_pkg::q_wr_t  q_wr_o
);
  import sbh_pkg::*;

  logic [HashW-1:0] running_d, running_q;
  logic [HashW-1:0] mixed;

  always_comb begin
    mixed     = has_char_i ? mix_char(running_q, key_char_i) : running_q;
    running_d = running_q;
    if (take_i) begin
      running_d = last_i ? '0 : mixed;
    end
  end

  // the final mix is left to the back end
  assign q_wr_o.push = take_i & last_i;
  assign q_wr_o.hash = mixed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
    end else begin
      running_q <= running_d;
    end
  end

endmodule

>>> hw/rtl/sbh_queue.sv
// short queue of pre-final key hashes between front and back end
`include "assert_macros.svh"
module sbh_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sbh_pkg::q_wr_t q_wr_i,
  input  logic           pop_i,
  output sbh_pkg::q_rd_t q_rd_o,
  output logic           full_o
);
  import sbh_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  logic [HashW-1:0] slot_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0]  cnt_d, cnt_q;
  logic             do_push, do_pop;

  assign do_push = q_wr_i.push & (cnt_q != FullCnt);
  assign do_pop  = pop_i & (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= q_wr_i.hash;
    end
  end

  assign q_rd_o.empty = (cnt_q == '0);
  assign q_rd_o.hash  = slot_q[rd_ptr_q];
  assign full_o       = (cnt_q == FullCnt);

  `SBH_NEVER(a_push_full, clk_i, rst_ni, q_wr_i.push && full_o)
  `SBH_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && q_rd_o.empty)
  `SBH_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= FullCnt)

endmodule

>>> hw/rtl/sbh_back.sv
// back end: final mix, magnitude and bit-serial modulo, then result register
`include "assert_macros.svh"
module sbh_back #(
  parameter int INDEX_BITS = sbh_pkg::IndexBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sbh_pkg::q_rd_t q_rd_i,
  output logic           pop_o,
  input  logic [sbh_pkg::CountW-1:0] bucket_count_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output logic [sbh_pkg::IndexW-1:0] bucket_index_o,
  output logic [sbh_pkg::HashW-1:0]  hash_value_o
);
  import sbh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIN,
    ST_MAG,
    ST_DIV,
    ST_DONE
  } state_e;

  localparam int StepW = $clog2(HashW);
  localparam logic [StepW-1:0] LastStep = StepW'(HashW - 1);
  localparam logic [IndexW-1:0] IdxMask =
    (INDEX_BITS >= IndexW) ? '1 : IndexW'((32'd1 << INDEX_BITS) - 32'd1);

  state_e            state_d, state_q;
  logic [HashW-1:0]  hash_d, hash_q;
  logic [HashW-1:0]  dvd_d, dvd_q;
  logic [CountW-1:0] rem_d, rem_q;
  logic [CountW-1:0] div_d, div_q;
  logic [StepW-1:0]  step_d, step_q;
  logic              out_valid_d, out_valid_q;
  logic [IndexW-1:0] out_idx_d, out_idx_q;
  logic [HashW-1:0]  out_hash_d, out_hash_q;
  logic [CountW:0]   trial;
  logic              out_free;

  assign trial    = {rem_q, dvd_q[HashW-1]};
  assign out_free = !out_valid_q || res_ready_i;

  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    div_d       = div_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    out_hash_d  = out_hash_q;
    pop_o       = 1'b0;

    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (!q_rd_i.empty) begin
          pop_o   = 1'b1;
          hash_d  = q_rd_i.hash;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        hash_d  = finish_mix(hash_q);
        div_d   = bucket_count_i;
        state_d = ST_MAG;
      end
      ST_MAG: begin
        // two's complement magnitude, the most negative value stays 2^31
        dvd_d   = hash_q[HashW-1] ? (~hash_q + 1'b1) : hash_q;
        rem_d   = '0;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // one restoring remainder step per cycle, msb first
        if (trial >= {1'b0, div_q}) begin
          rem_d = CountW'(trial - {1'b0, div_q});
        end else begin
          rem_d = trial[CountW-1:0];
        end
        dvd_d  = dvd_q << 1;
        step_d = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = (div_q == '0) ? '0 : (IndexW'(rem_q) & IdxMask);
          out_hash_d  = hash_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      hash_q      <= '0;
      dvd_q       <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      out_idx_q   <= '0;
      out_hash_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      hash_q      <= hash_d;
      dvd_q       <= dvd_d;
      rem_q       <= rem_d;
      div_q       <= div_d;
      out_idx_q   <= out_idx_d;
      out_hash_q  <= out_hash_d;
    end
  end

  assign res_valid_o    = out_valid_q;
  assign bucket_index_o = out_idx_q;
  assign hash_value_o   = out_hash_q;

  `SBH_ASSERT(a_rem_below_div, clk_i, rst_ni,
              (state_q == ST_DIV && div_q != '0) |-> (rem_q < div_q))
  `SBH_ASSERT(a_result_from_done, clk_i, rst_ni,
              $rose(out_valid_q) |-> $past(state_q == ST_DONE))
  `SBH_ASSERT(a_pop_from_idle, clk_i, rst_ni,
              pop_o |=> (state_q == ST_FIN))

endmodule

>>> hw/rtl/string_bucket_hash_core.sv
// top level of the string bucket hash core: ports, register file, front/queue/back
//
//  channel     | dir | payload
//  s_axis      | in  | tdata[7:0] key_char, tuser[0] has_char, tlast last
//  m_axis      | out | tdata[15:0] bucket_index, tdata[47:16] hash_value
//  apb         | in  | bucket_count at byte address 0
//
// the front end takes one character item per cycle unless the queue is full and
// keeps the running hash in a single register, so key bytes stream at full rate.
// each key then passes through the back end in order: pop, final mix, magnitude,
// 32 remainder steps of the bit-serial modulo unit and the result write; no new
// key is popped before the last one is written, which sets the key rate.
// a two-entry queue lets the front run ahead; s_axis stalls only when it is full.
// a finished result waits in the output register while the next key is worked on;
// the back end holds in its last step while that register is still occupied.
// reset clears the running hash, the queue and the back end; bucket_count to 16.
`include "assert_macros.svh"
module string_bucket_hash_core #(
  parameter int INDEX_BITS = sbh_pkg::IndexBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] key_char
  input  logic [0:0]  s_axis_tuser,   // [0] has_char
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] bucket_index, [47:16] hash_value
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sbh_pkg::*;

  logic [CountW-1:0] bucket_count_q, bucket_count_d;
  logic              cfg_wr;
  logic              take;
  logic              q_full;
  logic              pop;
  q_wr_t             q_wr;
  q_rd_t             q_rd;
  logic [IndexW-1:0] bucket_index;
  logic [HashW-1:0]  hash_value;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    bucket_count_d = bucket_count_q;
    if (cfg_wr && paddr[2] == RegBucketCount) begin
      bucket_count_d = pwdata[CountW-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegBucketCount: prdata = {{(32-CountW){1'b0}}, bucket_count_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= BucketCountRst;
    end else begin
      bucket_count_q <= bucket_count_d;
    end
  end

  assign s_axis_tready = !q_full;
  assign take = s_axis_tvalid & s_axis_tready;

  sbh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .key_char_i (s_axis_tdata),
    .has_char_i (s_axis_tuser[0]),
    .last_i     (s_axis_tlast),
    .q_wr_o     (q_wr)
  );

  sbh_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_wr_i (q_wr),
    .pop_i  (pop),
    .q_rd_o (q_rd),
    .full_o (q_full)
  );

  sbh_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_rd_i         (q_rd),
    .pop_o          (pop),
    .bucket_count_i (bucket_count_q),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .bucket_index_o (bucket_index),
    .hash_value_o   (hash_value)
  );

  assign m_axis_tdata = {hash_value, bucket_index};

  `SBH_ASSERT(a_stall_only_full, clk_i, rst_ni, !s_axis_tready |-> q_full)
  `SBH_ASSERT(a_push_on_last, clk_i, rst_ni, q_wr.push |-> (take && s_axis_tlast))
  `SBH_ASSERT(a_cfg_applied, clk_i, rst_ni,
              (cfg_wr && paddr[2] == RegBucketCount) |=> (bucket_count_q == $past(pwdata[15:0])))

endmodule
